FILE: sv/frag_pkg.sv
// Package with the shared types and constants of the fragment reassembler.
package frag_pkg;

	localparam int DATA_W = 8;
	localparam int STATUS_W = 3;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [DATA_W-1:0] MORE_TYPE_RST = 8'd254;
	localparam logic [DATA_W-1:0] END_TYPE_RST = 8'd255;

	// Register index taken from paddr[2].
	localparam logic REG_MORE_TYPE = 1'b0;
	localparam logic REG_END_TYPE = 1'b1;

	localparam logic REQ_DATA = 1'b0;
	localparam logic REQ_ABORT = 1'b1;

	typedef enum logic [2:0] {
		PH_TYPE  = 3'd0,
		PH_PLAIN = 3'd1,
		PH_FIRST = 3'd2,
		PH_MORE  = 3'd3,
		PH_LAST  = 3'd4,
		PH_DROP  = 3'd5
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK            = 3'd0,
		ST_END_NO_MSG    = 3'd1,
		ST_PLAIN_IN_FRAG = 3'd2,
		ST_EMPTY_FIRST   = 3'd3,
		ST_NESTED_TYPE   = 3'd4
	} status_t;

	typedef struct packed {
		logic [DATA_W-1:0] more_type;
		logic [DATA_W-1:0] end_type;
	} frag_cfg_t;

	typedef struct packed {
		logic              data_valid;
		logic [DATA_W-1:0] out_byte;
		logic              msg_start;
		logic [DATA_W-1:0] msg_type;
		logic              msg_end;
		logic              frame_done;
		status_t           frame_status;
	} frag_result_t;

endpackage

FILE: sv/frag_if.sv
// Valid/ready channel interfaces for the input bytes and the results.
interface frag_in_if;
	logic                      valid;
	logic                      ready;
	logic                      req_type;
	logic [frag_pkg::DATA_W-1:0] in_byte;
	logic                      frame_end;

	modport source (output valid, output req_type, output in_byte, output frame_end,
		input ready);
	modport sink (input valid, input req_type, input in_byte, input frame_end,
		output ready);
endinterface

interface frag_out_if;
	logic                          valid;
	logic                          ready;
	logic                          data_valid;
	logic [frag_pkg::DATA_W-1:0]   out_byte;
	logic                          msg_start;
	logic [frag_pkg::DATA_W-1:0]   msg_type;
	logic                          msg_end;
	logic                          frame_done;
	logic [frag_pkg::STATUS_W-1:0] frame_status;

	modport source (output valid, output data_valid, output out_byte, output msg_start,
		output msg_type, output msg_end, output frame_done, output frame_status,
		input ready);
	modport sink (input valid, input data_valid, input out_byte, input msg_start,
		input msg_type, input msg_end, input frame_done, input frame_status,
		output ready);
endinterface

FILE: sv/frag_core.sv
// Reassembly state machine: per-byte decode of frame type and message bounds.
module frag_core
	import frag_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              req_type,
	input  logic [DATA_W-1:0] in_byte,
	input  logic              frame_end,
	input  frag_cfg_t         cfg,
	output frag_result_t      res
);

	phase_t            phase_q, phase_d;
	logic              in_flight_q, in_flight_d;
	logic [DATA_W-1:0] inner_q, inner_d;
	status_t           pend_q, pend_d;

	logic is_more;
	logic is_end;

	assign is_more = (in_byte == cfg.more_type);
	assign is_end = (in_byte == cfg.end_type);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TYPE;
			in_flight_q <= 1'b0;
			inner_q     <= '0;
			pend_q      <= ST_OK;
		end else if (accept) begin
			phase_q     <= phase_d;
			in_flight_q <= in_flight_d;
			inner_q     <= inner_d;
			pend_q      <= pend_d;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		in_flight_d = in_flight_q;
		inner_d     = inner_q;
		pend_d      = pend_q;
		res         = '0;

		if (req_type == REQ_ABORT) begin
			phase_d     = PH_TYPE;
			in_flight_d = 1'b0;
			inner_d     = '0;
			pend_d      = ST_OK;
		end else begin
			unique case (phase_q)
				PH_TYPE: begin
					if (is_more) begin
						phase_d = in_flight_q ? PH_MORE : PH_FIRST;
					end else if (is_end) begin
						if (in_flight_q) begin
							phase_d = PH_LAST;
						end else begin
							phase_d = PH_DROP;
							pend_d  = ST_END_NO_MSG;
						end
					end else if (in_flight_q) begin
						phase_d = PH_DROP;
						pend_d  = ST_PLAIN_IN_FRAG;
					end else begin
						inner_d       = in_byte;
						phase_d       = PH_PLAIN;
						res.msg_start = 1'b1;
					end
				end
				PH_FIRST: begin
					if (is_more || is_end) begin
						phase_d = PH_DROP;
						pend_d  = ST_NESTED_TYPE;
					end else begin
						in_flight_d   = 1'b1;
						inner_d       = in_byte;
						phase_d       = PH_MORE;
						res.msg_start = 1'b1;
					end
				end
				PH_PLAIN, PH_MORE, PH_LAST: begin
					res.data_valid = 1'b1;
					res.out_byte   = in_byte;
				end
				default: begin
				end
			endcase

			// The message type reflects the state after this byte's decode.
			if (in_flight_d || phase_d == PH_PLAIN) begin
				res.msg_type = inner_d;
			end

			if (frame_end) begin
				res.frame_done = 1'b1;
				if (phase_d == PH_FIRST) begin
					res.frame_status = ST_EMPTY_FIRST;
				end else if (phase_d == PH_DROP) begin
					res.frame_status = pend_d;
				end
				if (phase_d == PH_PLAIN) begin
					res.msg_end = 1'b1;
					inner_d     = '0;
				end else if (phase_d == PH_LAST) begin
					res.msg_end = 1'b1;
					in_flight_d = 1'b0;
					inner_d     = '0;
				end
				phase_d = PH_TYPE;
				pend_d  = ST_OK;
			end
		end
	end

endmodule

FILE: sv/frag_skid.sv
// Two-entry output buffer: a result register backed by a skid register.
module frag_skid
	import frag_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  frag_result_t push_data,
	output logic         push_ready,
	output logic         pop_valid,
	input  logic         pop_ready,
	output frag_result_t pop_data
);

	frag_result_t main_q;
	frag_result_t skid_q;
	logic         main_valid_q;
	logic         skid_valid_q;
	logic         pop;

	assign push_ready = !skid_valid_q;
	assign pop_valid = main_valid_q;
	assign pop_data = main_q;
	assign pop = main_valid_q && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (!push) begin
				main_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!main_valid_q) begin
				main_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			if (!main_valid_q) begin
				main_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

endmodule

FILE: sv/fragment_reassembler.sv
// A request's result is written into the output buffer on the edge that accepts it.
// Throughput: one request per cycle while in_ch.ready is high; the whole per-byte decision
// is a few compares on small state between the input channel and the result register.
// A two-entry output buffer lets the block take a request while a result waits;
// in_ch.ready falls only when both entries are full.
// Reset (arst_n low) clears the reassembly state and sets more_type and end_type to 254, 255.
module fragment_reassembler
	import frag_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	frag_in_if.sink            in_ch,
	frag_out_if.source         out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	frag_cfg_t    cfg_q;
	frag_result_t res;
	frag_result_t out_res;
	logic         in_accept;
	logic         buf_ready;
	logic         cfg_write;

	// Configuration port. Writes complete in the access phase; pready never stalls.
	// Register selection uses paddr[2] only, so each register owns four byte addresses.
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.more_type <= MORE_TYPE_RST;
			cfg_q.end_type  <= END_TYPE_RST;
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_MORE_TYPE: cfg_q.more_type <= pwdata[DATA_W-1:0];
				REG_END_TYPE:  cfg_q.end_type  <= pwdata[DATA_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_MORE_TYPE: prdata[DATA_W-1:0] = cfg_q.more_type;
			REG_END_TYPE:  prdata[DATA_W-1:0] = cfg_q.end_type;
			default: prdata = '0;
		endcase
	end

	// A request is taken whenever the output buffer has a free entry.
	assign in_ch.ready = buf_ready;
	assign in_accept = in_ch.valid && buf_ready;

	// The core decodes each byte against the frame phase and updates the
	// reassembly state on the same edge that writes the result into the buffer.
	frag_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_accept),
		.req_type  (in_ch.req_type),
		.in_byte   (in_ch.in_byte),
		.frame_end (in_ch.frame_end),
		.cfg       (cfg_q),
		.res       (res)
	);

	frag_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_accept),
		.push_data  (res),
		.push_ready (buf_ready),
		.pop_valid  (out_ch.valid),
		.pop_ready  (out_ch.ready),
		.pop_data   (out_res)
	);

	assign out_ch.data_valid = out_res.data_valid;
	assign out_ch.out_byte = out_res.out_byte;
	assign out_ch.msg_start = out_res.msg_start;
	assign out_ch.msg_type = out_res.msg_type;
	assign out_ch.msg_end = out_res.msg_end;
	assign out_ch.frame_done = out_res.frame_done;
	assign out_ch.frame_status = out_res.frame_status;

endmodule

FILE: sv/frag_chk.sv
// Port-level checker for the fragment reassembler and its bind.
module frag_chk
	import frag_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic                data_valid,
	input logic [DATA_W-1:0]   out_byte,
	input logic                msg_start,
	input logic                frame_done,
	input logic [STATUS_W-1:0] frame_status
);

	// A nonzero status only comes with a frame end.
	a_status_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (frame_status != ST_OK) |-> frame_done)
		else $error("frame_status set without frame_done");

	// A message starts on a type byte, which is never payload.
	a_start_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && msg_start |-> !data_valid)
		else $error("msg_start together with data_valid");

	// Non-payload results carry a zero byte.
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !data_valid |-> (out_byte == '0))
		else $error("out_byte nonzero without data_valid");

	// A stalled result stays in place.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(frame_status))
		else $error("stalled result changed");

endmodule

bind fragment_reassembler frag_chk u_frag_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.data_valid   (out_ch.data_valid),
	.out_byte     (out_ch.out_byte),
	.msg_start    (out_ch.msg_start),
	.frame_done   (out_ch.frame_done),
	.frame_status (out_ch.frame_status)
);
